[design/page_and_subpage_free_list_allocator_macros.svh]
// assertion macros for the page and sub-page free-list allocator
// no dependencies; taken in by `include where assertions are written
`ifndef PAGE_AND_SUBPAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_AND_SUBPAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFLA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFLA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/pfla_pkg.sv]
// shared types and constants of the page and sub-page free-list allocator
// no dependencies
package pfla_pkg;

	localparam int PAGES_DEF  = 1024;
	localparam int BLOCKS_DEF = 4096;

	localparam int PAGE_NUM_W  = 20;
	localparam int BLOCK_NUM_W = 22;
	localparam int ADDR_W      = 32;
	localparam int FUNC_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 40;

	localparam logic [FUNC_W-1:0] FN_INIT       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PAGE_ALLOC = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PAGE_FREE  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_BLK_ALLOC  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_BLK_FREE   = 3'd4;

	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STS_TRUNC = 2'd3;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INIT_SET,
		ST_INIT_FILL,
		ST_PG_DATA,
		ST_BK_DATA,
		ST_SP_DATA,
		ST_SP_W0,
		ST_SP_W1,
		ST_SP_W2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

endpackage

[design/pfla_ram.sv]
// single write, single registered read port stack memory
// depends on pfla_pkg for the port control struct
module pfla_ram #(
	parameter int DEPTH = pfla_pkg::PAGES_DEF,
	parameter int WIDTH = pfla_pkg::PAGE_NUM_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  pfla_pkg::ram_ctl_t ctl,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/page_and_subpage_free_list_allocator.sv]
// Page and 1 KiB block free-list allocator: two LIFO stacks held in simple
// dual-port memories, driven by one sequencer that reuses a single incrementer.
// Depends on pfla_pkg, pfla_ram and the assertion macro header.
//
// One item is taken at a time; s_tready is high only while the sequencer is
// idle, and a finished result sits in the output register while the next item
// is taken. From acceptance to the result register the sequencer passes decode,
// then for page or block alloc the registered stack read, for free and unknown
// func nothing more, for a block alloc that splits a page the page read and
// three block writes, and for init the bound setup and one fill step per page
// pushed (at most PAGES). Init and split write one stack entry per cycle through
// the shared incrementer. No clearing pass after reset: the stack counts alone
// mark what is valid.
`include "page_and_subpage_free_list_allocator_macros.svh"
module page_and_subpage_free_list_allocator #(
	parameter int PAGES  = pfla_pkg::PAGES_DEF,
	parameter int BLOCKS = pfla_pkg::BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [pfla_pkg::ADDR_W-1:0]    cfg_data,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] func, [34:3] addr, [39:35] zero
	input  logic [pfla_pkg::S_TDATA_W-1:0] s_tdata,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] result_addr, [33:32] status, [39:34] zero
	output logic [pfla_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int PAW = $clog2(PAGES);
	localparam int BAW = $clog2(BLOCKS);
	localparam int PCW = $clog2(PAGES + 1);
	localparam int BCW = $clog2(BLOCKS + 1);
	localparam int PNW = pfla_pkg::PAGE_NUM_W;
	localparam int BNW = pfla_pkg::BLOCK_NUM_W;
	localparam int AW  = pfla_pkg::ADDR_W;
	localparam int SW  = pfla_pkg::STATUS_W;
	localparam logic [PNW:0]   PagesWide  = (PNW + 1)'(PAGES);
	localparam logic [PCW-1:0] PagesFull  = PCW'(PAGES);
	localparam logic [BCW-1:0] BlocksFull = BCW'(BLOCKS);
	localparam logic [BCW-1:0] SplitLeft  = BCW'(3);

	pfla_pkg::state_t state_q, state_d;

	logic [AW-1:0]  start_q, end_q;
	logic [PCW-1:0] page_count_q, page_count_d;
	logic [BCW-1:0] block_count_q, block_count_d;
	logic [PCW-1:0] n_q, n_d;
	logic [BNW-1:0] work_q, work_d;
	logic [BNW-1:0] add_y;
	logic [AW-1:0]  res_q, res_d;
	logic [SW-1:0]  st_q, st_d;
	logic [pfla_pkg::FUNC_W-1:0] func_q;
	logic [AW-1:0]  addr_q;
	logic           out_valid_q, out_valid_d, out_load;
	logic [AW-1:0]  out_res_q;
	logic [SW-1:0]  out_st_q;
	logic           accept;

	pfla_pkg::ram_ctl_t pg_ctl, bk_ctl;
	logic [PAW-1:0] pg_wa, pg_ra;
	logic [PNW-1:0] pg_wd, pg_rd;
	logic [BAW-1:0] bk_wa, bk_ra;
	logic [BNW-1:0] bk_wd, bk_rd;

	logic [PCW-1:0] pc_dec;
	logic [BCW-1:0] bc_dec;
	logic [PNW:0]   start_pg, end_pg, span;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == pfla_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(pfla_pkg::M_TDATA_W - AW - SW){1'b0}}, out_st_q, out_res_q};

	// shared incrementer: next page number during init, next block during split
	assign add_y = work_q + BNW'(1);

	assign pc_dec   = page_count_q - PCW'(1);
	assign bc_dec   = block_count_q - BCW'(1);
	assign start_pg = {1'b0, start_q[AW-1:12]} + (PNW + 1)'(start_q[11:0] != 12'd0);
	assign end_pg   = {1'b0, end_q[AW-1:12]};
	assign span     = end_pg - start_pg;

	pfla_ram #(.DEPTH(PAGES), .WIDTH(PNW), .AW(PAW)) u_page_ram (
		.clk  (clk),
		.ctl  (pg_ctl),
		.waddr(pg_wa),
		.wdata(pg_wd),
		.raddr(pg_ra),
		.rdata(pg_rd)
	);

	pfla_ram #(.DEPTH(BLOCKS), .WIDTH(BNW), .AW(BAW)) u_block_ram (
		.clk  (clk),
		.ctl  (bk_ctl),
		.waddr(bk_wa),
		.wdata(bk_wd),
		.raddr(bk_ra),
		.rdata(bk_rd)
	);

	always_comb begin
		state_d       = state_q;
		page_count_d  = page_count_q;
		block_count_d = block_count_q;
		n_d           = n_q;
		work_d        = work_q;
		res_d         = res_q;
		st_d          = st_q;
		out_load      = 1'b0;
		pg_ctl        = '0;
		bk_ctl        = '0;
		pg_wa         = page_count_q[PAW-1:0];
		pg_wd         = addr_q[AW-1:12];
		pg_ra         = pc_dec[PAW-1:0];
		bk_wa         = block_count_q[BAW-1:0];
		bk_wd         = addr_q[AW-1:10];
		bk_ra         = bc_dec[BAW-1:0];
		case (state_q)
			pfla_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = pfla_pkg::ST_DECODE;
				end
			end
			pfla_pkg::ST_DECODE: begin
				res_d   = '0;
				st_d    = pfla_pkg::STS_OK;
				state_d = pfla_pkg::ST_DONE;
				case (func_q)
					pfla_pkg::FN_INIT: begin
						page_count_d  = '0;
						block_count_d = '0;
						state_d       = pfla_pkg::ST_INIT_SET;
					end
					pfla_pkg::FN_PAGE_ALLOC: begin
						if (page_count_q == '0) begin
							st_d = pfla_pkg::STS_EMPTY;
						end else begin
							pg_ctl.re    = 1'b1;
							page_count_d = pc_dec;
							state_d      = pfla_pkg::ST_PG_DATA;
						end
					end
					pfla_pkg::FN_PAGE_FREE: begin
						if (page_count_q == PagesFull) begin
							st_d = pfla_pkg::STS_FULL;
						end else begin
							pg_ctl.we    = 1'b1;
							page_count_d = page_count_q + PCW'(1);
						end
					end
					pfla_pkg::FN_BLK_ALLOC: begin
						if (block_count_q != '0) begin
							bk_ctl.re     = 1'b1;
							block_count_d = bc_dec;
							state_d       = pfla_pkg::ST_BK_DATA;
						end else if (page_count_q != '0) begin
							pg_ctl.re    = 1'b1;
							page_count_d = pc_dec;
							state_d      = pfla_pkg::ST_SP_DATA;
						end else begin
							st_d = pfla_pkg::STS_EMPTY;
						end
					end
					pfla_pkg::FN_BLK_FREE: begin
						if (block_count_q == BlocksFull) begin
							st_d = pfla_pkg::STS_FULL;
						end else begin
							bk_ctl.we     = 1'b1;
							block_count_d = block_count_q + BCW'(1);
						end
					end
					default: begin
						state_d = pfla_pkg::ST_DONE;
					end
				endcase
			end
			pfla_pkg::ST_INIT_SET: begin
				work_d = {1'b0, start_pg};
				if (start_pg < end_pg) begin
					if (span > PagesWide) begin
						n_d  = PagesFull;
						st_d = pfla_pkg::STS_TRUNC;
					end else begin
						n_d = PCW'(span);
					end
					state_d = pfla_pkg::ST_INIT_FILL;
				end else begin
					state_d = pfla_pkg::ST_DONE;
				end
			end
			pfla_pkg::ST_INIT_FILL: begin
				pg_ctl.we    = 1'b1;
				pg_wd        = work_q[PNW-1:0];
				page_count_d = page_count_q + PCW'(1);
				work_d       = add_y;
				if (page_count_d == n_q) begin
					state_d = pfla_pkg::ST_DONE;
				end
			end
			pfla_pkg::ST_PG_DATA: begin
				res_d   = {pg_rd, 12'd0};
				state_d = pfla_pkg::ST_DONE;
			end
			pfla_pkg::ST_BK_DATA: begin
				res_d   = {bk_rd, 10'd0};
				state_d = pfla_pkg::ST_DONE;
			end
			pfla_pkg::ST_SP_DATA: begin
				work_d  = {pg_rd, 2'b00};
				state_d = pfla_pkg::ST_SP_W0;
			end
			pfla_pkg::ST_SP_W0, pfla_pkg::ST_SP_W1, pfla_pkg::ST_SP_W2: begin
				// blocks +0..+2 go to the stack, +3 is handed out directly
				bk_ctl.we     = 1'b1;
				bk_wd         = work_q;
				block_count_d = block_count_q + BCW'(1);
				work_d        = add_y;
				if (state_q == pfla_pkg::ST_SP_W0) begin
					state_d = pfla_pkg::ST_SP_W1;
				end else if (state_q == pfla_pkg::ST_SP_W1) begin
					state_d = pfla_pkg::ST_SP_W2;
				end else begin
					res_d   = {add_y, 10'd0};
					state_d = pfla_pkg::ST_DONE;
				end
			end
			pfla_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = pfla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfla_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pfla_pkg::ST_IDLE;
			page_count_q  <= '0;
			block_count_q <= '0;
			out_valid_q   <= 1'b0;
			start_q       <= '0;
			end_q         <= '0;
		end else begin
			state_q       <= state_d;
			page_count_q  <= page_count_d;
			block_count_q <= block_count_d;
			out_valid_q   <= out_valid_d;
			if (cfg_we && cfg_index == pfla_pkg::REG_START) begin
				start_q <= cfg_data;
			end
			if (cfg_we && cfg_index == pfla_pkg::REG_END) begin
				end_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q    <= n_d;
		work_q <= work_d;
		res_q  <= res_d;
		st_q   <= st_d;
		if (accept) begin
			func_q <= s_tdata[pfla_pkg::FUNC_W-1:0];
			addr_q <= s_tdata[pfla_pkg::FUNC_W +: AW];
		end
		if (out_load) begin
			out_res_q <= res_q;
			out_st_q  <= st_q;
		end
	end

	`PFLA_ASSERT_IMPL(a_page_count_range, clk, arst_n, 1'b1, page_count_q <= PagesFull, "page count past capacity")
	`PFLA_ASSERT_IMPL(a_block_count_range, clk, arst_n, 1'b1, block_count_q <= BlocksFull, "block count past capacity")
	`PFLA_ASSERT_NEXT(a_accept_decode, clk, arst_n, accept, state_q == pfla_pkg::ST_DECODE, "accepted item not decoded")
	`PFLA_ASSERT_NEXT(a_split_count, clk, arst_n, state_q == pfla_pkg::ST_SP_W2, block_count_q == SplitLeft, "split left wrong block count")
	`PFLA_ASSERT_IMPL(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == pfla_pkg::ST_DONE), "result shown outside done")

endmodule
